[rtl/flc8_pkg.sv]
// shared types, constants and the crc-8 step function of the framed link checker
`default_nettype none

package flc8_pkg;

  localparam int TLM_PAYLOAD_BYTES_DEF = 12;
  localparam int ARINC_PAYLOAD_BYTES   = 4;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  localparam logic [7:0] TLM_START_RST   = 8'h55;
  localparam logic [7:0] ARINC_START_RST = 8'hA5;
  localparam logic [7:0] LABEL_RST       = 8'h12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TLM_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARINC_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL       = 2'd2;

  typedef enum logic {
    KIND_TLM   = 1'b0,
    KIND_ARINC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_CRC    = 2'd1,
    VERDICT_LABEL  = 2'd2,
    VERDICT_PARITY = 2'd3
  } verdict_t;

  // one finished frame, handed from the parser to the counter stage
  typedef struct packed {
    kind_t    kind;
    verdict_t verdict;
  } frame_rec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // reflected crc-8, one byte, lsb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       fb;
    c = crc;
    b = data;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/flc8_front.sv]
// frame parser: start byte hunt, crc and word gathering, verdict per frame
`default_nettype none

module flc8_front import flc8_pkg::*; #(
  parameter int TELEMETRY_PAYLOAD_BYTES = TLM_PAYLOAD_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  input  wire logic                 byte_valid,
  input  wire logic [BYTE_W-1:0]    rx_byte,
  output logic                      byte_ready,
  input  wire q_stat_t              q_stat,
  output logic                      push,
  output frame_rec_t                rec
);

  localparam int TlmLeftW = $clog2(TELEMETRY_PAYLOAD_BYTES + 2);
  localparam int ArcLeftW = $clog2(ARINC_PAYLOAD_BYTES + 2);
  localparam int LeftW    = (TlmLeftW > ArcLeftW) ? TlmLeftW : ArcLeftW;
  localparam logic [LeftW-1:0] TlmLeftInit = LeftW'(TELEMETRY_PAYLOAD_BYTES + 1);
  localparam logic [LeftW-1:0] ArcLeftInit = LeftW'(ARINC_PAYLOAD_BYTES + 1);
  localparam logic [LeftW-1:0] LeftOne     = LeftW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TLM,
    ST_ARINC
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [LeftW-1:0] left_r, left_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [7:0]       tlm_start_r, arinc_start_r, label_r;
  logic             take;

  assign byte_ready = !q_stat.full;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    mode_nxt    = mode_r;
    left_nxt    = left_r;
    crc_nxt     = crc_r;
    word_nxt    = word_r;
    push        = 1'b0;
    rec.kind    = KIND_TLM;
    rec.verdict = VERDICT_OK;
    if (mode_r == ST_ARINC) begin
      rec.kind = KIND_ARINC;
      if (crc_r != rx_byte) begin
        rec.verdict = VERDICT_CRC;
      end else if (word_r[7:0] != label_r) begin
        rec.verdict = VERDICT_LABEL;
      end else if (!(^word_r)) begin
        rec.verdict = VERDICT_PARITY;
      end
    end else if (crc_r != rx_byte) begin
      rec.verdict = VERDICT_CRC;
    end
    if (take) begin
      case (mode_r)
        ST_TLM, ST_ARINC: begin
          if (left_r > LeftOne) begin
            crc_nxt  = crc8_update(crc_r, rx_byte);
            word_nxt = {rx_byte, word_r[31:8]};
            left_nxt = left_r - LeftOne;
          end else begin
            // crc byte closes the frame
            push     = 1'b1;
            mode_nxt = ST_IDLE;
            left_nxt = '0;
            crc_nxt  = CRC_INIT;
          end
        end
        default: begin
          crc_nxt  = CRC_INIT;
          word_nxt = '0;
          if (rx_byte == tlm_start_r) begin
            mode_nxt = ST_TLM;
            left_nxt = TlmLeftInit;
          end else if (rx_byte == arinc_start_r) begin
            mode_nxt = ST_ARINC;
            left_nxt = ArcLeftInit;
          end else begin
            mode_nxt = ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ST_IDLE;
      left_r        <= '0;
      crc_r         <= CRC_INIT;
      word_r        <= '0;
      tlm_start_r   <= TLM_START_RST;
      arinc_start_r <= ARINC_START_RST;
      label_r       <= LABEL_RST;
    end else begin
      mode_r <= mode_nxt;
      left_r <= left_nxt;
      crc_r  <= crc_nxt;
      word_r <= word_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TLM_START:   tlm_start_r   <= cfg_wdata;
          CFG_ARINC_START: arinc_start_r <= cfg_wdata;
          CFG_LABEL:       label_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/flc8_queue.sv]
// short queue of finished frame records between parser and counters
`default_nettype none

module flc8_queue import flc8_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  input  wire logic       pop,
  output frame_rec_t      head,
  output q_stat_t         stat
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  frame_rec_t        entry_r [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CntW'(QUEUE_DEPTH));
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CntW'(1);
        2'b01:   count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/flc8_back.sv]
// result stage: six wrapping counters and the output register
`default_nettype none

module flc8_back import flc8_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire frame_rec_t head,
  input  wire q_stat_t    q_stat,
  output logic            pop,
  output logic            res_valid,
  input  wire logic       res_ready,
  output kind_t           res_kind,
  output verdict_t        res_verdict,
  output logic [CNT_W-1:0] tlm_ok_cnt,
  output logic [CNT_W-1:0] tlm_crc_cnt,
  output logic [CNT_W-1:0] arc_ok_cnt,
  output logic [CNT_W-1:0] arc_crc_cnt,
  output logic [CNT_W-1:0] arc_par_cnt,
  output logic [CNT_W-1:0] arc_lbl_cnt
);

  logic             valid_r;
  kind_t            kind_r;
  verdict_t         verdict_r;
  logic [CNT_W-1:0] tlm_ok_r, tlm_crc_r, arc_ok_r, arc_crc_r, arc_par_r, arc_lbl_r;
  logic             is_arc;

  // counters only move on a pop, and a pop only when the output slot is free,
  // so they double as the result payload
  assign pop    = !q_stat.empty && (!valid_r || res_ready);
  assign is_arc = (head.kind == KIND_ARINC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      kind_r    <= KIND_TLM;
      verdict_r <= VERDICT_OK;
      tlm_ok_r  <= '0;
      tlm_crc_r <= '0;
      arc_ok_r  <= '0;
      arc_crc_r <= '0;
      arc_par_r <= '0;
      arc_lbl_r <= '0;
    end else begin
      if (pop) begin
        valid_r   <= 1'b1;
        kind_r    <= head.kind;
        verdict_r <= head.verdict;
        case (head.verdict)
          VERDICT_OK: begin
            if (is_arc) begin
              arc_ok_r <= arc_ok_r + CNT_W'(1);
            end else begin
              tlm_ok_r <= tlm_ok_r + CNT_W'(1);
            end
          end
          VERDICT_CRC: begin
            if (is_arc) begin
              arc_crc_r <= arc_crc_r + CNT_W'(1);
            end else begin
              tlm_crc_r <= tlm_crc_r + CNT_W'(1);
            end
          end
          VERDICT_LABEL:  arc_lbl_r <= arc_lbl_r + CNT_W'(1);
          VERDICT_PARITY: arc_par_r <= arc_par_r + CNT_W'(1);
          default: ;
        endcase
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign res_valid   = valid_r;
  assign res_kind    = kind_r;
  assign res_verdict = verdict_r;
  assign tlm_ok_cnt  = tlm_ok_r;
  assign tlm_crc_cnt = tlm_crc_r;
  assign arc_ok_cnt  = arc_ok_r;
  assign arc_crc_cnt = arc_crc_r;
  assign arc_par_cnt = arc_par_r;
  assign arc_lbl_cnt = arc_lbl_r;

endmodule

`default_nettype wire

[rtl/framed_link_crc8_arinc_checker.sv]
// top level of the framed link crc-8 checker with arinc label and parity checks
//
//   channel | direction | transfer carries
//   --------+-----------+-----------------------------------------------------
//   in_     | slave     | one received link byte
//   out_    | master    | frame kind, verdict and the six frame counters
//   cfg_    | write     | start byte values and expected arinc label
//
// one byte is taken per cycle while in_tready is high; a frame's result is written into
// the record queue at the edge that takes its crc byte and is loaded into the output
// register once that is free (parser to queue to output register)
// the rate is set by the parser, which folds one byte into the crc per cycle
// in_tready falls only while the four-entry record queue is full, that is when
// the result side has stalled long enough for four frames to pile up behind the
// one held at the output
// reset is synchronous and active low; the queue is empty, counters are zero
// and the start and label registers hold their defaults
`default_nettype none

module framed_link_crc8_arinc_checker import flc8_pkg::*; #(
  parameter int TELEMETRY_PAYLOAD_BYTES = TLM_PAYLOAD_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_wdata,
  // received bytes
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  // frame results
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic                      out_tuser,  // [0] frame_kind
  // [1:0] verdict, [33:2] telemetry_ok_count, [65:34] telemetry_crc_fail_count,
  // [97:66] arinc_ok_count, [129:98] arinc_crc_fail_count,
  // [161:130] arinc_parity_fail_count, [193:162] arinc_label_fail_count,
  // [199:194] zero
  output logic [199:0]              out_tdata
);

  q_stat_t          q_stat;
  logic             q_push, q_pop;
  frame_rec_t       push_rec, head_rec;
  kind_t            res_kind;
  verdict_t         res_verdict;
  logic [CNT_W-1:0] tlm_ok_cnt, tlm_crc_cnt, arc_ok_cnt, arc_crc_cnt, arc_par_cnt, arc_lbl_cnt;

  // front: hunts for start bytes, runs the crc, judges each frame
  flc8_front #(
    .TELEMETRY_PAYLOAD_BYTES(TELEMETRY_PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (in_tvalid),
    .rx_byte    (in_tdata),
    .byte_ready (in_tready),
    .q_stat     (q_stat),
    .push       (q_push),
    .rec        (push_rec)
  );

  // queue decouples the byte side from result back-pressure
  flc8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head     (head_rec),
    .stat     (q_stat)
  );

  // back: counts frames and holds the result until it is taken
  flc8_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head_rec),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_kind    (res_kind),
    .res_verdict (res_verdict),
    .tlm_ok_cnt  (tlm_ok_cnt),
    .tlm_crc_cnt (tlm_crc_cnt),
    .arc_ok_cnt  (arc_ok_cnt),
    .arc_crc_cnt (arc_crc_cnt),
    .arc_par_cnt (arc_par_cnt),
    .arc_lbl_cnt (arc_lbl_cnt)
  );

  assign out_tuser = res_kind;
  assign out_tdata = {6'b0, arc_lbl_cnt, arc_par_cnt, arc_crc_cnt, arc_ok_cnt,
                      tlm_crc_cnt, tlm_ok_cnt, res_verdict};

`ifndef SYNTHESIS
  // the parser never closes a frame into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("frame record pushed into a full queue");

  // the result stage never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty))
    else $error("frame record popped from an empty queue");

  // label and parity verdicts belong to arinc frames only
  a_tlm_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_TLM) |->
      (res_verdict == VERDICT_OK || res_verdict == VERDICT_CRC))
    else $error("telemetry result with an arinc-only verdict");

  // a popped record shows up on the output in the next cycle
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_tvalid && out_tuser == $past(head_rec.kind)
               && res_verdict == $past(head_rec.verdict)))
    else $error("popped frame record not presented on the output");
`endif

endmodule

`default_nettype wire

[bench/framed_link_crc8_arinc_checker_test.sv]
// self-checking bench for the framed link crc-8 checker with arinc label and parity checks
`timescale 1ns / 100ps

module framed_link_crc8_arinc_checker_test;
  import flc8_pkg::*;

  localparam int TLM_BYTES     = TLM_PAYLOAD_BYTES_DEF;
  localparam int SETTLE_CYCLES = 16;      // parser, record queue and output register, with margin
  localparam int LONG_HOLD     = 200;     // long result-side stall, enough to fill the record queue
  localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest correct run
  localparam int PHASE_BYTES   = 360;     // framed bytes per random phase

  // register index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    HUNT,
    IN_TLM,
    IN_ARINC
  } link_mode_t;

  // one frame verdict with the counter snapshot taken after that frame
  typedef struct packed {
    kind_t       kind;
    verdict_t    verdict;
    logic [31:0] tlm_ok;
    logic [31:0] tlm_crc_bad;
    logic [31:0] arinc_ok;
    logic [31:0] arinc_crc_bad;
    logic [31:0] arinc_parity_bad;
    logic [31:0] arinc_label_bad;
  } frame_result_t;

  // every input known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 out_tuser;
  logic [199:0]         out_tdata;

  framed_link_crc8_arinc_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be offered, and results owed by the block
  logic [7:0]    tx_bytes[$];
  frame_result_t frames_due[$];

  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned framed_bytes   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 32;
  int unsigned recv_idle_pct  = 64;
  int unsigned sink_hold_left = 0;
  bit          sink_hold_go   = 1'b0;

  // register values the generator builds frames for
  logic [7:0] gen_tlm_start   = TLM_START_RST;
  logic [7:0] gen_arinc_start = ARINC_START_RST;
  logic [7:0] gen_label       = LABEL_RST;

  // register copies as the block sees them, updated on the same edges
  logic [7:0] seen_tlm_start;
  logic [7:0] seen_arinc_start;
  logic [7:0] seen_label;

  // frame parser state of the predictor
  link_mode_t    link_mode;
  logic [4:0]    link_left;
  logic [7:0]    link_crc;
  logic [31:0]   link_word;
  frame_result_t tally;

  // reflected crc-8, polynomial 0x8c, bits taken lsb first
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    logic [7:0] x;
    c = acc;
    x = d;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ x[0]) begin
        c = (c >> 1) ^ 8'h8C;
      end else begin
        c = c >> 1;
      end
      x = x >> 1;
    end
    return c;
  endfunction

  // feeds one received byte through the frame parser; returns 1 when a frame closes
  function automatic bit link_byte(input logic [7:0] b, output frame_result_t res);
    res = tally;
    if (link_mode == HUNT) begin
      // equal start values resolve to telemetry since it is tested first
      if (b == seen_tlm_start) begin
        link_mode = IN_TLM;
        link_left = 5'(TLM_BYTES + 1);
      end else if (b == seen_arinc_start) begin
        link_mode = IN_ARINC;
        link_left = 5'(ARINC_PAYLOAD_BYTES + 1);
      end
      link_crc  = 8'h00;
      link_word = '0;
      return 1'b0;
    end
    // payload: start values here are plain data, no resync
    if (link_left > 1) begin
      link_crc  = crc8_fold(link_crc, b);
      link_word = {b, link_word[31:8]};
      link_left = link_left - 1'b1;
      return 1'b0;
    end
    // crc byte closes the frame
    if (link_mode == IN_TLM) begin
      tally.kind = KIND_TLM;
      if (link_crc == b) begin
        tally.verdict = VERDICT_OK;
        tally.tlm_ok++;
      end else begin
        tally.verdict = VERDICT_CRC;
        tally.tlm_crc_bad++;
      end
    end else begin
      // crc first, then label, parity only once the label matches
      tally.kind = KIND_ARINC;
      if (link_crc != b) begin
        tally.verdict = VERDICT_CRC;
        tally.arinc_crc_bad++;
      end else if (link_word[7:0] != seen_label) begin
        tally.verdict = VERDICT_LABEL;
        tally.arinc_label_bad++;
      end else if (!(^link_word)) begin
        tally.verdict = VERDICT_PARITY;
        tally.arinc_parity_bad++;
      end else begin
        tally.verdict = VERDICT_OK;
        tally.arinc_ok++;
      end
    end
    link_mode = HUNT;
    link_left = '0;
    link_crc  = 8'h00;
    res = tally;
    return 1'b1;
  endfunction

  // register copies follow the write port edge for edge; spare index is ignored
  always @(posedge clk) begin
    if (!rst_n) begin
      seen_tlm_start   <= TLM_START_RST;
      seen_arinc_start <= ARINC_START_RST;
      seen_label       <= LABEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TLM_START:   seen_tlm_start   <= cfg_wdata;
        CFG_ARINC_START: seen_arinc_start <= cfg_wdata;
        CFG_LABEL:       seen_label       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // driver: offers queued bytes with random gaps, predicts on every accepted transfer
  always @(posedge clk) begin : byte_driver
    frame_result_t res;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      link_mode = HUNT;
      link_left = '0;
      link_crc  = 8'h00;
      link_word = '0;
      tally     = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        bytes_accepted++;
        if (link_byte(in_tdata, res)) begin
          frames_due.push_back(res);
        end
      end
      // only move on once the current byte has gone, one assignment per edge
      if (!in_tvalid || in_tready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= tx_bytes.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long result-side stall, counted down on its own
  always @(posedge clk) begin
    if (sink_hold_left != 0) begin
      sink_hold_left <= sink_hold_left - 1;
    end else if (sink_hold_go) begin
      sink_hold_left <= LONG_HOLD;
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    end
  endtask

  // monitor: random back-pressure, each result transfer checked against the oldest expectation
  always @(posedge clk) begin : result_monitor
    frame_result_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with no frame pending", '0, out_tdata[31:0]);
        end else begin
          due = frames_due.pop_front();
          if (out_tuser !== due.kind)
            report_mismatch("frame_kind", 32'(due.kind), 32'(out_tuser));
          if (out_tdata[1:0] !== due.verdict)
            report_mismatch("verdict", 32'(due.verdict), 32'(out_tdata[1:0]));
          if (out_tdata[33:2] !== due.tlm_ok)
            report_mismatch("telemetry_ok_count", due.tlm_ok, out_tdata[33:2]);
          if (out_tdata[65:34] !== due.tlm_crc_bad)
            report_mismatch("telemetry_crc_fail_count", due.tlm_crc_bad, out_tdata[65:34]);
          if (out_tdata[97:66] !== due.arinc_ok)
            report_mismatch("arinc_ok_count", due.arinc_ok, out_tdata[97:66]);
          if (out_tdata[129:98] !== due.arinc_crc_bad)
            report_mismatch("arinc_crc_fail_count", due.arinc_crc_bad, out_tdata[129:98]);
          if (out_tdata[161:130] !== due.arinc_parity_bad)
            report_mismatch("arinc_parity_fail_count", due.arinc_parity_bad,
                            out_tdata[161:130]);
          if (out_tdata[193:162] !== due.arinc_label_bad)
            report_mismatch("arinc_label_fail_count", due.arinc_label_bad,
                            out_tdata[193:162]);
          if (out_tdata[199:194] !== 6'd0)
            report_mismatch("tdata padding", '0, 32'(out_tdata[199:194]));
        end
      end
      out_tready <= (sink_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  // telemetry frame; optionally seeds the payload with start values and both byte extremes
  task automatic put_telemetry(input bit corrupt, input bit with_starts);
    logic [7:0] acc;
    logic [7:0] d;
    acc = 8'h00;
    put_byte(gen_tlm_start);
    for (int i = 0; i < TLM_BYTES; i++) begin
      d = 8'($urandom_range(255));
      if (with_starts) begin
        case (i)
          0: d = gen_tlm_start;
          1: d = gen_arinc_start;
          2: d = 8'h00;
          3: d = 8'hFF;
          default: ;
        endcase
      end
      acc = crc8_fold(acc, d);
      put_byte(d);
    end
    put_byte(corrupt ? acc ^ 8'($urandom_range(255, 1)) : acc);
    framed_bytes += TLM_BYTES + 2;
  endtask

  // arinc word frame, label in the low byte, sent little-endian
  task automatic put_arinc(input logic [7:0] label, input logic [23:0] upper, input bit corrupt);
    logic [31:0] w;
    logic [7:0]  acc;
    w   = {upper, label};
    acc = 8'h00;
    put_byte(gen_arinc_start);
    for (int i = 0; i < ARINC_PAYLOAD_BYTES; i++) begin
      acc = crc8_fold(acc, w[8*i +: 8]);
      put_byte(w[8*i +: 8]);
    end
    put_byte(corrupt ? acc ^ 8'($urandom_range(255, 1)) : acc);
    framed_bytes += ARINC_PAYLOAD_BYTES + 2;
  endtask

  // mostly well-formed frames with random content, some bad crcs, labels and stray bytes
  task automatic put_random_traffic(input int unsigned target);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = framed_bytes + target;
    while (framed_bytes < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        put_arinc(($urandom_range(99) < 75) ? gen_label : 8'($urandom_range(255)),
                  24'($urandom), $urandom_range(99) < 20);
      end else if (pick < 85) begin
        put_telemetry($urandom_range(99) < 25, 1'b0);
      end else begin
        put_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // wait until every byte is taken and every frame result is back, then let the pipe empty
  task automatic settle();
    while (bytes_accepted != bytes_queued || frames_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] tlm_start, input logic [7:0] arinc_start,
                            input logic [7:0] label);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TLM_START;
    cfg_wdata <= tlm_start;
    @(posedge clk);
    cfg_index <= CFG_ARINC_START;
    cfg_wdata <= arinc_start;
    @(posedge clk);
    cfg_index <= CFG_LABEL;
    cfg_wdata <= label;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_tlm_start   = tlm_start;
    gen_arinc_start = arinc_start;
    gen_label       = label;
  endtask

  initial begin
    logic [7:0] pick_start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values: stray bytes at both extremes, then every verdict
    put_byte(8'h00);
    put_byte(8'hFF);
    put_telemetry(1'b0, 1'b1);                   // start values inside the payload
    put_telemetry(1'b1, 1'b0);                   // telemetry crc mismatch
    put_arinc(gen_label, 24'h000001, 1'b0);      // odd parity, all checks pass
    put_arinc(gen_label, 24'h000001, 1'b1);      // crc mismatch wins over everything
    put_arinc(gen_label ^ 8'h01, 24'h000000, 1'b0); // wrong label, parity not looked at
    put_arinc(gen_label, 24'h000003, 1'b0);      // even parity
    put_arinc(gen_label, 24'hFFFFFF, 1'b0);      // all upper bits set, even parity
    settle();

    // both start values equal: the shared byte must open a telemetry frame
    write_regs(8'h00, 8'h00, 8'hFF);
    put_telemetry(1'b0, 1'b0);
    put_byte(8'h00);
    for (int i = 0; i < TLM_BYTES + 1; i++) put_byte(8'hFF);
    settle();

    // random phase one: sender idles now and then, receiver more often
    write_regs(8'hFF, 8'h00, 8'h00);
    put_random_traffic(PHASE_BYTES);
    settle();

    // random phase two: roles swapped, and a write to the unused index that must change nothing
    send_idle_pct = 64;
    recv_idle_pct = 32;
    write_regs(8'h3C, 8'hFF, 8'hFF);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
    put_random_traffic(PHASE_BYTES);
    settle();

    // random phase three: no idling; first a long result stall so the record queue fills
    // and the block has to hold off incoming bytes
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pick_start = 8'($urandom_range(255));
    write_regs(pick_start, pick_start ^ 8'($urandom_range(255, 1)), 8'($urandom_range(255)));
    @(negedge clk) sink_hold_go = 1'b1;
    do @(negedge clk); while (sink_hold_left == 0);
    sink_hold_go = 1'b0;
    repeat (10) put_arinc(gen_label, 24'($urandom), 1'b0);
    settle();
    put_random_traffic(PHASE_BYTES);
    settle();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
